// ===== design/d2pc_pkg.sv =====
// Shared widths, register codes and controller/datapath interface types.
`default_nettype none
package d2pc_pkg;

	// Image geometry
	localparam int MAX_DIM   = 4096;
	localparam int DIM_W     = $clog2(MAX_DIM);
	localparam int DIM_CFG_W = 13;

	// Field and register widths
	localparam int DEPTH_W   = 16;
	localparam int PAR_W     = 16;
	localparam int XY_W      = 29;
	localparam int CFG_IDX_W = 3;

	// Back-projection arithmetic: signed numerator, its magnitude, product
	localparam int NUM_W     = 18;
	localparam int NUM_MAG_W = 17;
	localparam int PROD_W    = NUM_MAG_W + DEPTH_W;
	localparam int DIV_CNT_W = $clog2(PROD_W + 1);

	// Output stream packing: x, y, z from the lowest bit up, byte padded
	localparam int OUT_FIELDS_W = 2 * XY_W + DEPTH_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Register reset values
	localparam logic [DIM_CFG_W-1:0] IMG_WIDTH_RST  = DIM_CFG_W'(640);
	localparam logic [DIM_CFG_W-1:0] IMG_HEIGHT_RST = DIM_CFG_W'(480);
	localparam logic [PAR_W-1:0]     FOCAL_X_RST    = PAR_W'(8192);
	localparam logic [PAR_W-1:0]     FOCAL_Y_RST    = PAR_W'(8192);
	localparam logic [PAR_W-1:0]     CENTER_X_RST   = PAR_W'(5120);
	localparam logic [PAR_W-1:0]     CENTER_Y_RST   = PAR_W'(3840);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMG_WIDTH  = 3'd0,
		CFG_IMG_HEIGHT = 3'd1,
		CFG_FOCAL_X    = 3'd2,
		CFG_FOCAL_Y    = 3'd3,
		CFG_CENTER_X   = 3'd4,
		CFG_CENTER_Y   = 3'd5
	} cfg_index_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic mul_en;
		logic div_start;
		logic div_sel_y;
		logic cap_x;
		logic cap_y;
		logic load_out;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic depth_nz;
		logic last;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== design/d2pc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module d2pc_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [d2pc_pkg::PROD_W-1:0]   dividend,
	input  wire [d2pc_pkg::PAR_W-1:0]    divisor,
	output logic                         done,
	output logic [d2pc_pkg::PROD_W-1:0]  quotient
);
	import d2pc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PAR_W-1:0]     den_q;
	logic [PAR_W-1:0]     rem_q;
	logic [PROD_W-1:0]    quo_q;

	logic [PAR_W:0]       trial;
	logic [PAR_W:0]       diff;
	logic                 ge;

	// Trial subtraction of the shifted remainder
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// Control: step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[PAR_W-1:0] : trial[PAR_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== design/d2pc_datapath.sv =====
// Registers, pixel counters, numerators, products, divider and output register.
`default_nettype none
module d2pc_datapath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  d2pc_pkg::ctrl_cmd_t              cmd,
	output d2pc_pkg::dp_status_t             status,
	input  wire                              cfg_valid,
	input  wire [d2pc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [d2pc_pkg::PAR_W-1:0]        cfg_data,
	input  wire [d2pc_pkg::DEPTH_W-1:0]      depth_in,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [d2pc_pkg::OUT_DATA_W-1:0]  out_data,
	output logic                             out_point_valid,
	output logic                             out_frame_end
);
	import d2pc_pkg::*;

	// Configuration registers
	logic [DIM_CFG_W-1:0] img_width_q;
	logic [DIM_CFG_W-1:0] img_height_q;
	logic [PAR_W-1:0]     focal_x_q;
	logic [PAR_W-1:0]     focal_y_q;
	logic [PAR_W-1:0]     center_x_q;
	logic [PAR_W-1:0]     center_y_q;

	// Pixel position
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;

	// Per-item working registers
	logic [DEPTH_W-1:0]   d_q;
	logic                 nz_q;
	logic                 last_q;
	logic [NUM_MAG_W-1:0] nx_mag_q;
	logic [NUM_MAG_W-1:0] ny_mag_q;
	logic                 nx_neg_q;
	logic                 ny_neg_q;
	logic [PROD_W-1:0]    px_q;
	logic [PROD_W-1:0]    py_q;
	logic [XY_W-1:0]      x_q;
	logic [XY_W-1:0]      y_q;

	// Output register
	logic               out_valid_q;
	logic               out_pv_q;
	logic               out_fe_q;
	logic [XY_W-1:0]    out_x_q;
	logic [XY_W-1:0]    out_y_q;
	logic [DEPTH_W-1:0] out_z_q;

	logic [DIM_W-1:0]        wm1;
	logic [DIM_W-1:0]        hm1;
	logic                    row_end;
	logic                    last;
	logic signed [DIM_W:0]   v_s;
	logic signed [NUM_W-1:0] num_x;
	logic signed [NUM_W-1:0] num_y;
	logic signed [NUM_W-1:0] neg_x;
	logic signed [NUM_W-1:0] neg_y;
	logic [PAR_W-1:0]        den_x;
	logic [PAR_W-1:0]        den_y;
	logic [PROD_W-1:0]       div_dividend;
	logic [PAR_W-1:0]        div_divisor;
	logic                    div_done;
	logic [PROD_W-1:0]       div_quo;

	localparam logic [PROD_W-1:0] XY_POS_LIM = PROD_W'((64'd1 << (XY_W - 1)) - 64'd1);
	localparam logic [PROD_W-1:0] XY_NEG_LIM = PROD_W'(64'd1 << (XY_W - 1));

	// Saturate a quotient magnitude with its sign into the signed field
	function automatic logic [XY_W-1:0] sat_xy(logic [PROD_W-1:0] q, logic neg);
		logic [XY_W-1:0] r;
		if (neg) begin
			if (q > XY_NEG_LIM) r = {1'b1, {(XY_W-1){1'b0}}};
			else                r = -q[XY_W-1:0];
		end else begin
			if (q > XY_POS_LIM) r = {1'b0, {(XY_W-1){1'b1}}};
			else                r = q[XY_W-1:0];
		end
		return r;
	endfunction

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= IMG_WIDTH_RST;
			img_height_q <= IMG_HEIGHT_RST;
			focal_x_q    <= FOCAL_X_RST;
			focal_y_q    <= FOCAL_Y_RST;
			center_x_q   <= CENTER_X_RST;
			center_y_q   <= CENTER_Y_RST;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_IMG_WIDTH:  img_width_q  <= cfg_data[DIM_CFG_W-1:0];
				CFG_IMG_HEIGHT: img_height_q <= cfg_data[DIM_CFG_W-1:0];
				CFG_FOCAL_X:    focal_x_q    <= cfg_data;
				CFG_FOCAL_Y:    focal_y_q    <= cfg_data;
				CFG_CENTER_X:   center_x_q   <= cfg_data;
				CFG_CENTER_Y:   center_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Last column and row index, dimensions clamped to one and MAX_DIM
	always_comb begin
		if (img_width_q == '0)                         wm1 = '0;
		else if (img_width_q > DIM_CFG_W'(MAX_DIM))    wm1 = DIM_W'(MAX_DIM - 1);
		else                                           wm1 = DIM_W'(img_width_q - 1'b1);
		if (img_height_q == '0)                        hm1 = '0;
		else if (img_height_q > DIM_CFG_W'(MAX_DIM))   hm1 = DIM_W'(MAX_DIM - 1);
		else                                           hm1 = DIM_W'(img_height_q - 1'b1);
	end

	assign row_end = col_q >= wm1;
	assign last    = row_end && (row_q >= hm1);

	// Numerators: 16*u - cx and 16*(h-1-row) - cy
	assign v_s   = $signed({1'b0, hm1}) - $signed({1'b0, row_q});
	assign num_x = $signed(NUM_W'({col_q, 4'b0000})) - $signed(NUM_W'(center_x_q));
	assign num_y = NUM_W'($signed({v_s, 4'b0000})) - $signed(NUM_W'(center_y_q));
	assign neg_x = -num_x;
	assign neg_y = -num_y;

	// Zero focal length acts as one
	assign den_x = (focal_x_q == '0) ? PAR_W'(1) : focal_x_q;
	assign den_y = (focal_y_q == '0) ? PAR_W'(1) : focal_y_q;

	// Pixel counters advance on every accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Capture sample and numerator magnitudes
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			d_q      <= depth_in;
			nz_q     <= depth_in != '0;
			last_q   <= last;
			nx_neg_q <= num_x[NUM_W-1];
			ny_neg_q <= num_y[NUM_W-1];
			nx_mag_q <= num_x[NUM_W-1] ? neg_x[NUM_MAG_W-1:0] : num_x[NUM_MAG_W-1:0];
			ny_mag_q <= num_y[NUM_W-1] ? neg_y[NUM_MAG_W-1:0] : num_y[NUM_MAG_W-1:0];
		end
	end

	// Magnitude products
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			px_q <= PROD_W'(nx_mag_q) * PROD_W'(d_q);
			py_q <= PROD_W'(ny_mag_q) * PROD_W'(d_q);
		end
	end

	// Shared divider, x first then y
	assign div_dividend = cmd.div_sel_y ? py_q : px_q;
	assign div_divisor  = cmd.div_sel_y ? den_y : den_x;

	d2pc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Signed, saturated coordinates
	always_ff @(posedge clk) begin
		if (cmd.cap_x) x_q <= sat_xy(div_quo, nx_neg_q);
		if (cmd.cap_y) y_q <= sat_xy(div_quo, ny_neg_q);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_pv_q <= nz_q;
			out_fe_q <= last_q;
			out_x_q  <= nz_q ? x_q : '0;
			out_y_q  <= nz_q ? y_q : '0;
			out_z_q  <= d_q;
		end
	end

	assign status.depth_nz = depth_in != '0;
	assign status.last     = last;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign out_data        = OUT_DATA_W'({out_z_q, out_y_q, out_x_q});
	assign out_point_valid = out_pv_q;
	assign out_frame_end   = out_fe_q;

endmodule
`default_nettype wire

// ===== design/d2pc_ctrl.sv =====
// Sequencer for one sample: capture, multiply, two divides, result hand-off; a zero sample skips the arithmetic.
`default_nettype none
module d2pc_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  d2pc_pkg::dp_status_t  status,
	output d2pc_pkg::ctrl_cmd_t   cmd
);
	import d2pc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_XSTART,
		ST_XWAIT,
		ST_YSTART,
		ST_YWAIT,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					if (status.depth_nz)  state_d = ST_MUL;
					else if (status.last) state_d = ST_EMIT;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_XSTART;
			end
			ST_XSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_XWAIT;
			end
			ST_XWAIT: begin
				if (status.div_done) begin
					cmd.cap_x = 1'b1;
					state_d   = ST_YSTART;
				end
			end
			ST_YSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_y = 1'b1;
				state_d       = ST_YWAIT;
			end
			ST_YWAIT: begin
				if (status.div_done) begin
					cmd.cap_y = 1'b1;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = state_q == ST_IDLE;

endmodule
`default_nettype wire

// ===== design/depth_to_point_cloud.sv =====
// Top level: depth image stream to pinhole back-projected point stream.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: depth_mm
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: x,y,z  tuser: valid  tlast: frame end
//  cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// A non-zero sample goes, acceptance to next acceptance, through accept, multiply,
// two divides on the shared radix-2 divider (start, 33 quotient bits, done) and hand-off.
// A zero sample skips the arithmetic and is handed off only on the frame's last pixel.
// Reset restores the register defaults and clears the pixel counters.
// A stalled output holds the sequencer in its hand-off step; one finished
// result waits in the output register while the next sample is taken.
`default_nettype none
module depth_to_point_cloud (
	input  wire                              clk,
	input  wire                              arst_n,
	// input stream
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire [d2pc_pkg::DEPTH_W-1:0]      s_axis_tdata,   // [15:0] depth_mm
	// output stream
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [d2pc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [28:0] x, [57:29] y, [73:58] z
	output logic                             m_axis_tuser,   // [0] point_valid
	output logic                             m_axis_tlast,   // frame_end
	// register writes
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [d2pc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [d2pc_pkg::PAR_W-1:0]        cfg_data
);
	import d2pc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Registers are always writable
	assign cfg_ready = 1'b1;

	d2pc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	d2pc_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.depth_in        (s_axis_tdata),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_data        (m_axis_tdata),
		.out_point_valid (m_axis_tuser),
		.out_frame_end   (m_axis_tlast)
	);

endmodule
`default_nettype wire
